/* rtl/core/kmpq_pkg.sv */
// Package for the keyed max-priority queue: widths, transfer payload types,
// cell broadcast and status structs, command codes and controller states.
// No dependencies; every other file in rtl/core imports it.
`timescale 1ns / 1ps
`default_nettype none

package kmpq_pkg;

  // Table size and derived widths
  localparam int DEPTH        = 16;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int MAX_RESULTS  = 16;
  localparam int REMAIN_W     = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int CMD_W        = 3;
  localparam int KEY_W        = 16;
  localparam int PAYLOAD_W    = 32;
  localparam int PRIO_W       = 3;
  localparam int LIMIT_W      = 5;
  localparam int PRIO_LEVELS  = 1 << PRIO_W;

  // Register port
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int REG_IDX_W    = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ATTACHED = '0;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RAISE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEMOTE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  // Result kinds
  localparam logic RESULT_POP  = 1'b0;
  localparam logic RESULT_DROP = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [KEY_W-1:0]     item_key;
    logic [PAYLOAD_W-1:0] item_payload;
    logic [PRIO_W-1:0]    item_priority;
    logic [LIMIT_W-1:0]   pop_limit;
  } in_data_t;

  typedef struct packed {
    logic                 result_kind;
    logic [KEY_W-1:0]     out_key;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 last_of_run;
  } out_data_t;

  // One table entry as held in a cell
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [PRIO_W-1:0]    prio;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_UPSERT,
    CELL_RAISE,
    CELL_DEMOTE,
    CELL_POP
  } cell_op_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t             op;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [PRIO_W-1:0]    prio;
    logic [PRIO_W-1:0]    max_prio;
  } bcast_t;

  // Status from each cell back to the controller
  typedef struct packed {
    logic                   match;
    logic                   sel;
    logic [PRIO_LEVELS-1:0] prio_hot;
  } cell_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_POP
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/kmpq_cell.sv */
// One table slot of the queue: holds key, payload and priority, matches keys,
// takes part in the oldest-first pop chain and shifts down from its right neighbor.
// Depends on kmpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmpq_cell (
  input  wire                  clk,
  input  kmpq_pkg::bcast_t     bc,
  input  wire                  occupied,
  input  wire                  append_en,
  input  wire                  found_in,
  input  kmpq_pkg::entry_t     right_entry,
  output kmpq_pkg::entry_t     entry,
  output logic                 found_out,
  output kmpq_pkg::cell_stat_t stat
);
  import kmpq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match;
  logic   cand;

  // Compare against the broadcast key and the current maximum priority
  assign match     = occupied && (entry_r.key == bc.key);
  assign cand      = occupied && (entry_r.prio == bc.max_prio);
  assign found_out = found_in || cand;

  assign stat.match    = match;
  assign stat.sel      = cand && !found_in;
  assign stat.prio_hot = occupied ? (PRIO_LEVELS'(1) << entry_r.prio) : '0;
  assign entry         = entry_r;

  // Apply the broadcast operation to this slot
  always_comb begin
    entry_nxt = entry_r;
    unique case (bc.op)
      CELL_UPSERT: begin
        if (match) begin
          entry_nxt.payload = bc.payload;
          if (bc.prio > entry_r.prio) begin
            entry_nxt.prio = bc.prio;
          end
        end else if (append_en) begin
          entry_nxt.key     = bc.key;
          entry_nxt.payload = bc.payload;
          entry_nxt.prio    = bc.prio;
        end
      end
      CELL_RAISE: begin
        if (match && (bc.prio > entry_r.prio)) begin
          entry_nxt.prio = bc.prio;
        end
      end
      CELL_DEMOTE: begin
        if (occupied) begin
          entry_nxt.prio = bc.prio;
        end
      end
      CELL_POP: begin
        // Close the gap: the popped slot and all after it take the next entry
        if (found_out) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/keyed_max_priority_queue_top.sv */
// Top level of the keyed max-priority queue: command controller, entry count,
// register port, result register and the row of kmpq_cell slots.
// Depends on kmpq_pkg and kmpq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Keyed max-priority queue of DEPTH (16) entries held in arrival order in a row
// of cells. Enqueue upserts by key (payload replaced, priority only raised) or
// appends; a new key on a full table yields one drop result. Tick pops up to
// min(pop_limit, 16) entries, highest priority first and oldest first on ties,
// and only while consumer_attached (register 0 at byte address 0) is set.
// One command is handled at a time: the input is stalled from acceptance until
// the command is done. Enqueue, raise, demote, clear and unknown commands pass
// through accept and execute; a tick then alternates, for each popped entry,
// between finding the maximum priority across the cells and popping and
// shifting the row, and a pop or drop result waits while out_stall holds the result register.
// The last result of each command carries last_of_run.
module keyed_max_priority_queue_top (
  input  wire                               clk,
  input  wire                               rst_n,
  // Command channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  kmpq_pkg::in_data_t                in_data,
  // Result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output kmpq_pkg::out_data_t               out_data,
  // Register port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [kmpq_pkg::PADDR_W-1:0]      paddr,
  input  wire  [kmpq_pkg::PDATA_W-1:0]      pwdata,
  output logic [kmpq_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import kmpq_pkg::*;

  state_t     state_r, state_nxt;
  in_data_t   cmd_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [REMAIN_W-1:0] remain_r, remain_nxt;
  logic [PRIO_W-1:0]   max_prio_r, max_prio_nxt;
  logic                attached_r;
  logic                out_valid_r;
  out_data_t           out_data_r;

  bcast_t     bc;
  entry_t     entries   [DEPTH];
  cell_stat_t stats     [DEPTH];
  logic [DEPTH:0]       found;
  logic [DEPTH-1:0]     match_vec;
  logic [DEPTH-1:0]     sel_vec;
  logic                 any_match;
  logic                 full;
  logic                 drop;
  logic                 out_free;
  logic                 out_load;
  out_data_t            out_load_data;
  logic [PRIO_LEVELS-1:0] prio_or;
  entry_t               popped;
  logic                 pop_last;
  logic                 tick_go;
  logic [REMAIN_W-1:0]  limit_sat;

  // Register port: single control register, writes complete in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_ATTACHED) ?
                  {{(PDATA_W-1){1'b0}}, attached_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1:2] == REG_ATTACHED)) begin
      attached_r <= pwdata[0];
    end
  end

  // Cell row
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    kmpq_cell u_cell (
      .clk         (clk),
      .bc          (bc),
      .occupied    (CNT_W'(i) < count_r),
      .append_en   ((count_r == CNT_W'(i)) && !any_match),
      .found_in    (found[i]),
      .right_entry ((i == DEPTH - 1) ? entries[i] : entries[(i + 1) % DEPTH]),
      .entry       (entries[i]),
      .found_out   (found[i+1]),
      .stat        (stats[i])
    );
    assign match_vec[i] = stats[i].match;
    assign sel_vec[i]   = stats[i].sel;
  end

  // Reduce cell status: key hit, priority levels present, popped entry
  always_comb begin
    prio_or = '0;
    popped  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      prio_or = prio_or | stats[i].prio_hot;
      if (sel_vec[i]) begin
        popped = popped | entries[i];
      end
    end
  end

  always_comb begin
    max_prio_nxt = '0;
    for (int l = 0; l < PRIO_LEVELS; l++) begin
      if (prio_or[l]) begin
        max_prio_nxt = PRIO_W'(l);
      end
    end
  end

  assign any_match = |match_vec;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign drop      = (cmd_r.cmd == CMD_ENQUEUE) && !any_match && full;
  assign out_free  = !out_valid_r || !out_stall;
  assign tick_go   = attached_r && (cmd_r.pop_limit != '0) && (count_r != '0);
  assign limit_sat = (cmd_r.pop_limit > LIMIT_W'(MAX_RESULTS)) ?
                     REMAIN_W'(MAX_RESULTS) : REMAIN_W'(cmd_r.pop_limit);
  assign pop_last  = (remain_r == REMAIN_W'(1)) || (count_r == CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_r.cmd == CMD_TICK) begin
          state_nxt = tick_go ? ST_SEARCH : ST_IDLE;
        end else if (!drop || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (out_free) begin
          state_nxt = pop_last ? ST_IDLE : ST_SEARCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the controller: cell broadcast, count, pop budget, result load
  always_comb begin
    bc.op         = CELL_IDLE;
    bc.key        = cmd_r.item_key;
    bc.payload    = cmd_r.item_payload;
    bc.prio       = cmd_r.item_priority;
    bc.max_prio   = max_prio_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    out_load      = 1'b0;
    out_load_data = '0;
    unique case (state_r)
      ST_EXEC: begin
        unique case (cmd_r.cmd)
          CMD_ENQUEUE: begin
            bc.op = CELL_UPSERT;
            if (drop) begin
              out_load                  = out_free;
              out_load_data.result_kind = RESULT_DROP;
              out_load_data.out_key     = cmd_r.item_key;
              out_load_data.out_payload = cmd_r.item_payload;
              out_load_data.last_of_run = 1'b1;
            end else if (!any_match) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          CMD_RAISE: begin
            bc.op = CELL_RAISE;
          end
          CMD_DEMOTE: begin
            bc.op = CELL_DEMOTE;
          end
          CMD_TICK: begin
            remain_nxt = limit_sat;
          end
          CMD_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            bc.op = CELL_IDLE;
          end
        endcase
      end
      ST_POP: begin
        if (out_free) begin
          bc.op                     = CELL_POP;
          out_load                  = 1'b1;
          out_load_data.result_kind = RESULT_POP;
          out_load_data.out_key     = popped.key;
          out_load_data.out_payload = popped.payload;
          out_load_data.last_of_run = pop_last;
          count_nxt                 = count_r - CNT_W'(1);
          remain_nxt                = remain_r - REMAIN_W'(1);
        end
      end
      default: begin
        bc.op = CELL_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
    end
  end

  // Hold the accepted command and the searched maximum
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r <= in_data;
    end
    if (state_r == ST_SEARCH) begin
      max_prio_r <= max_prio_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // Result register: load on a new result, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("key present in more than one cell");

  a_pop_select: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> $onehot(sel_vec))
    else $error("pop without exactly one selected cell");

  a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == ST_EXEC || state_r == ST_POP))
    else $error("result loaded outside execute or pop");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP && out_free) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not shrink the table by one");
`endif

endmodule

`default_nettype wire

/* test/keyed_max_priority_queue_top_test.sv */
// Self-checking testbench for keyed_max_priority_queue_top: directed and random
// command streams with a table predictor, randomized stalls and register writes.
// Depends on kmpq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module keyed_max_priority_queue_top_test;
  import kmpq_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;
  localparam logic [PADDR_W-1:0] ATTACHED_ADDR = {REG_ATTACHED, 2'b00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_data_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_data_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Predicted queue contents, oldest slot first
  logic [KEY_W-1:0]     slot_keys [DEPTH];
  logic [PAYLOAD_W-1:0] slot_payloads [DEPTH];
  logic [PRIO_W-1:0]    slot_prios [DEPTH];
  int                   slot_count = 0;
  logic                 consumer_bound = 1'b0;

  out_data_t pending_results[$];
  out_data_t seen_result;
  logic [KEY_W-1:0] key_pool [64];

  int error_count = 0;
  int command_count = 0;
  int checked_count = 0;
  int drop_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int stall_phase = 0;

  keyed_max_priority_queue_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result-side stall pattern: free-running, random, or mostly-stalled windows
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(32, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((stall_phase % 8) < 5);
    endcase
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0h key %0h payload %0h last %0h",
               out_data.result_kind, out_data.out_key, out_data.out_payload,
               out_data.last_of_run);
        error_count++;
      end else begin
        seen_result = pending_results.pop_front();
        checked_count++;
        if (out_data.result_kind !== seen_result.result_kind) begin
          $error("result_kind: expected %0h actual %0h",
                 seen_result.result_kind, out_data.result_kind);
          error_count++;
        end
        if (out_data.out_key !== seen_result.out_key) begin
          $error("out_key: expected %0h actual %0h", seen_result.out_key, out_data.out_key);
          error_count++;
        end
        if (out_data.out_payload !== seen_result.out_payload) begin
          $error("out_payload: expected %0h actual %0h",
                 seen_result.out_payload, out_data.out_payload);
          error_count++;
        end
        if (out_data.last_of_run !== seen_result.last_of_run) begin
          $error("last_of_run: expected %0h actual %0h",
                 seen_result.last_of_run, out_data.last_of_run);
          error_count++;
        end
      end
    end
  end

  // Apply one accepted command to the predicted table and queue its results
  function automatic void apply_to_table(in_data_t c);
    int pos;
    int best;
    int budget;
    int produced;
    out_data_t r;
    pos = -1;
    produced = 0;
    for (int i = 0; i < slot_count; i++)
      if (pos < 0 && slot_keys[i] == c.item_key) pos = i;
    case (c.cmd)
      CMD_ENQUEUE: begin
        if (pos >= 0) begin
          if (c.item_priority > slot_prios[pos]) slot_prios[pos] = c.item_priority;
          slot_payloads[pos] = c.item_payload;
        end else if (slot_count < DEPTH) begin
          slot_keys[slot_count] = c.item_key;
          slot_payloads[slot_count] = c.item_payload;
          slot_prios[slot_count] = c.item_priority;
          slot_count++;
        end else begin
          r.result_kind = RESULT_DROP;
          r.out_key = c.item_key;
          r.out_payload = c.item_payload;
          r.last_of_run = 1'b0;
          pending_results.insert(pending_results.size(), r);
          produced++;
          drop_count++;
        end
      end
      CMD_RAISE: begin
        if (pos >= 0 && c.item_priority > slot_prios[pos]) slot_prios[pos] = c.item_priority;
      end
      CMD_DEMOTE: begin
        for (int i = 0; i < slot_count; i++) slot_prios[i] = c.item_priority;
      end
      CMD_TICK: begin
        if (consumer_bound && c.pop_limit != 0) begin
          budget = (c.pop_limit > MAX_RESULTS) ? MAX_RESULTS : int'(c.pop_limit);
          while (budget > 0 && slot_count > 0) begin
            // Pick the highest priority; strict compare keeps the oldest on ties
            best = 0;
            for (int i = 1; i < slot_count; i++)
              if (slot_prios[i] > slot_prios[best]) best = i;
            r.result_kind = RESULT_POP;
            r.out_key = slot_keys[best];
            r.out_payload = slot_payloads[best];
            r.last_of_run = 1'b0;
            pending_results.insert(pending_results.size(), r);
            produced++;
            // Close the gap, keeping arrival order
            for (int i = best; i + 1 < slot_count; i++) begin
              slot_keys[i] = slot_keys[i + 1];
              slot_payloads[i] = slot_payloads[i + 1];
              slot_prios[i] = slot_prios[i + 1];
            end
            slot_count--;
            budget--;
          end
        end
      end
      CMD_CLEAR: slot_count = 0;
      default: ;
    endcase
    if (produced > 0) pending_results[pending_results.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic in_data_t make_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                        logic [PAYLOAD_W-1:0] payload,
                                        logic [PRIO_W-1:0] prio,
                                        logic [LIMIT_W-1:0] limit);
    in_data_t c;
    c.cmd = cmd;
    c.item_key = key;
    c.item_payload = payload;
    c.item_priority = prio;
    c.pop_limit = limit;
    return c;
  endfunction

  // Mostly pooled keys so upserts and raises hit; some fully random noise
  function automatic in_data_t random_command(int pool_size);
    in_data_t c;
    int roll;
    c.item_key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_size - 1)]
                                               : KEY_W'($urandom);
    c.item_payload = $urandom;
    c.item_priority = PRIO_W'($urandom_range(0, PRIO_LEVELS - 1));
    roll = $urandom_range(0, 99);
    if (roll < 10) c.pop_limit = '0;
    else if (roll < 70) c.pop_limit = LIMIT_W'($urandom_range(1, 4));
    else if (roll < 90) c.pop_limit = LIMIT_W'($urandom_range(5, MAX_RESULTS));
    else c.pop_limit = LIMIT_W'($urandom_range(MAX_RESULTS + 1, (1 << LIMIT_W) - 1));
    roll = $urandom_range(0, 99);
    if (roll < 45) c.cmd = CMD_ENQUEUE;
    else if (roll < 60) c.cmd = CMD_RAISE;
    else if (roll < 65) c.cmd = CMD_DEMOTE;
    else if (roll < 90) c.cmd = CMD_TICK;
    else if (roll < 95) c.cmd = CMD_CLEAR;
    else c.cmd = CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
    return c;
  endfunction

  // Hold one command until its transfer, then continue the burst or idle
  task automatic send_command(in_data_t c);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_to_table(c);
    command_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  // Drop valid, drain every predicted result, then let a silent command finish
  task automatic settle_until_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic register_access(input bit is_write, input logic [PDATA_W-1:0] wdata,
                                 output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= ATTACHED_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_consumer_attached(logic value);
    logic [PDATA_W-1:0] rdata;
    settle_until_idle();
    register_access(1'b1, PDATA_W'(value), rdata);
    consumer_bound = value;
    // Idle the port between the write and the readback
    @(posedge clk);
    register_access(1'b0, '0, rdata);
    if (rdata[0] !== value) begin
      $error("consumer_attached readback: expected %0h actual %0h", value, rdata[0]);
      error_count++;
    end
  endtask

  // Ticks with no consumer bound pop nothing
  task automatic test_detached_tick();
    send_command(make_cmd(CMD_ENQUEUE, '0, '0, '0, '0));
    send_command(make_cmd(CMD_TICK, '0, '0, '0, 5'd5));
    set_consumer_attached(1'b1);
  endtask

  // Fill the table, drop a new key, then upsert present keys while full
  task automatic test_full_table();
    for (int i = 1; i < DEPTH; i++) begin
      if (i == DEPTH - 1)
        send_command(make_cmd(CMD_ENQUEUE, '1, '1, '1, '0));
      else
        send_command(make_cmd(CMD_ENQUEUE, {8'(i), 8'($urandom)}, $urandom,
                              PRIO_W'($urandom_range(0, PRIO_LEVELS - 1)), '0));
    end
    send_command(make_cmd(CMD_ENQUEUE, 16'h8000 | 16'($urandom_range(0, 255)), $urandom,
                          3'd4, '0));
    send_command(make_cmd(CMD_ENQUEUE, '0, 32'hA5A5_5A5A, 3'd5, '0));
    send_command(make_cmd(CMD_ENQUEUE, '1, '0, 3'd2, '0));
  endtask

  // Raise, zero-limit tick, reserved code, demote ties, saturated and empty ticks
  task automatic test_priority_updates();
    logic [KEY_W-1:0] third_key;
    third_key = slot_keys[3];
    send_command(make_cmd(CMD_RAISE, 16'h8001, '0, '1, '0));
    send_command(make_cmd(CMD_RAISE, third_key, '0, 3'd6, '0));
    send_command(make_cmd(CMD_TICK, '0, '0, '0, '0));
    send_command(make_cmd(CMD_RESERVED_HI, '1, '1, '1, '1));
    send_command(make_cmd(CMD_TICK, '0, '0, '0, 5'd2));
    send_command(make_cmd(CMD_DEMOTE, '0, '0, 3'd4, '0));
    send_command(make_cmd(CMD_TICK, '0, '0, '0, '1));
    send_command(make_cmd(CMD_TICK, '0, '0, '0, 5'd16));
  endtask

  task automatic test_random_phase(logic attached, int n_items, int pool_size);
    set_consumer_attached(attached);
    for (int i = 0; i < pool_size; i++) key_pool[i] = KEY_W'($urandom);
    for (int i = 0; i < n_items; i++) send_command(random_command(pool_size));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_detached_tick();
    test_full_table();
    test_priority_updates();
    test_random_phase(1'b1, 100, 24);
    test_random_phase(1'b0, 50, 24);
    test_random_phase(1'b1, 110, 40);
    test_random_phase(1'b1, 100, 10);
    settle_until_idle();
    $display("Sent %0d commands across attached/detached phases; checked %0d results",
             command_count, checked_count);
    $display("Full-table drops seen: %0d; errors: %0d", drop_count, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/kmpq_pkg.sv
rtl/core/kmpq_cell.sv
rtl/core/keyed_max_priority_queue_top.sv
test/keyed_max_priority_queue_top_test.sv
